[design/rtccal_pkg.sv]
// shared types, register map and constants for the rtc clock calendar register file
package rtccal_pkg;

    localparam int unsigned NUM_CTL  = 14;
    localparam int unsigned RAM_DEPTH = 64;

    localparam logic [1:0] CMD_ADDR  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [3:0] REG_SEC   = 4'd0;
    localparam logic [3:0] REG_MIN   = 4'd2;
    localparam logic [3:0] REG_HOUR  = 4'd4;
    localparam logic [3:0] REG_WDAY  = 4'd6;
    localparam logic [3:0] REG_DATE  = 4'd7;
    localparam logic [3:0] REG_MONTH = 4'd8;
    localparam logic [3:0] REG_YEAR  = 4'd9;
    localparam logic [3:0] REG_A     = 4'd10;
    localparam logic [3:0] REG_B     = 4'd11;
    localparam logic [3:0] REG_C     = 4'd12;
    localparam logic [3:0] REG_D     = 4'd13;

    localparam logic [5:0] RAM_BASE  = 6'd14;

    localparam logic [23:0] TPS_RESET = 24'd1000000;

    localparam logic [7:0] CTL_RESET [NUM_CTL] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h00, 8'h03,
        8'h05, 8'h12, 8'h78, 8'h00, 8'h02, 8'h00, 8'h00
    };

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic       acc;
        logic [1:0] cmd;
        logic [5:0] addr;
        logic [7:0] data;
    } t_bus_op;

    typedef struct packed {
        logic       rd_en;
        logic [5:0] rd_addr;
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
    } t_ram_req;

endpackage

[design/rtccal_nvram.sv]
// battery-backed ram bytes: synchronous memory with valid bits and write forwarding
module rtccal_nvram
    import rtccal_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ram_req i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] r_vld_bits;
    logic [7:0] r_rdata;
    logic       r_rvld;
    logic       r_fwd;
    logic [7:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata    <= r_mem[i_req.rd_addr];
            r_fwd_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
            r_rvld     <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld_bits[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rvld <= r_vld_bits[i_req.rd_addr];
                r_fwd  <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
            end
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : (r_rvld ? r_rdata : 8'h00);

endmodule

[design/rtccal_time.sv]
// clock and control registers, prescaler and the one-second carry cascade
module rtccal_time
    import rtccal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  t_bus_op     i_op,
    output logic [7:0]  o_ctl_rdata
);

    logic [7:0]  r_regs [NUM_CTL];
    logic [7:0]  n_regs [NUM_CTL];
    logic [23:0] r_presc;
    logic [23:0] n_presc;
    logic [23:0] r_tps;

    logic       bin;
    logic       h24;
    logic       is_ctl;
    logic [3:0] ctl_idx;
    logic [7:0] msk;
    logic [8:0] s_nxt;
    logic [8:0] m_nxt;
    logic [8:0] h_nxt;
    logic [8:0] w_nxt;
    logic [8:0] d_nxt;
    logic [8:0] mo_nxt;
    logic [8:0] y_nxt;
    logic [8:0] md;
    logic [8:0] yd;
    logic [3:0] mi;
    logic [4:0] days;

    function automatic logic [8:0] f_dec(input logic [7:0] v, input logic b);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = v[3:0];
        hi = v[7:4];
        if (lo > 4'd9) lo = 4'd9;
        if (hi > 4'd9) hi = 4'd9;
        return b ? {1'b0, v} : (9'(hi) * 9'd10 + 9'(lo));
    endfunction

    function automatic logic [7:0] f_enc(input logic [8:0] n, input logic b);
        logic [6:0]  v;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  u;
        v = n[6:0];
        p = 15'(v) * 15'd205;
        t = p[14:11];
        u = 4'(v - 7'(t) * 7'd10);
        return b ? n[7:0] : {t, u};
    endfunction

    function automatic logic [8:0] f_bump(input logic [7:0] v, input logic [8:0] maxv,
                                          input logic [8:0] rstv, input logic b);
        logic [8:0] n;
        logic       w;
        n = f_dec(v, b) + 9'd1;
        w = n > maxv;
        if (w) n = rstv;
        return {w, f_enc(n, b)};
    endfunction

    function automatic logic [8:0] f_hours(input logic [7:0] raw, input logic b,
                                           input logic is24);
        logic [8:0] hv;
        logic [8:0] hm;
        logic [7:0] o;
        logic       w;
        if (is24) begin
            hv = f_dec(raw, b) + 9'd1;
        end else begin
            hv = f_dec({1'b0, raw[6:0]}, b) + (raw[7] ? 9'd12 : 9'd0);
        end
        w = hv > 9'd23;
        if (w) hv = 9'd0;
        hm = (hv >= 9'd12) ? hv - 9'd12 : hv;
        if (is24) begin
            o = f_enc(hv, b);
        end else begin
            o = f_enc(hm + 9'd1, b) | ((hv >= 9'd12) ? 8'h80 : 8'h00);
        end
        return {w, o};
    endfunction

    assign bin     = r_regs[REG_B][2];
    assign h24     = r_regs[REG_B][1];
    assign is_ctl  = i_op.addr < RAM_BASE;
    assign ctl_idx = i_op.addr[3:0];

    always_comb begin
        if (!is_ctl) begin
            o_ctl_rdata = 8'h00;
        end else if (ctl_idx == REG_D) begin
            o_ctl_rdata = r_regs[ctl_idx] | 8'h80;
        end else begin
            o_ctl_rdata = r_regs[ctl_idx];
        end
    end

    always_comb begin
        md = f_dec(r_regs[REG_MONTH], bin);
        yd = f_dec(r_regs[REG_YEAR], bin);
        if (md == 9'd0) begin
            mi = 4'd0;
        end else if (md > 9'd12) begin
            mi = 4'd11;
        end else begin
            mi = 4'(md - 9'd1);
        end
        days = MONTH_LEN[mi];
        if (mi == 4'd1 && yd[1:0] == 2'b00) days = 5'd29;
    end

    assign s_nxt  = f_bump(r_regs[REG_SEC], 9'd59, 9'd0, bin);
    assign m_nxt  = f_bump(r_regs[REG_MIN], 9'd59, 9'd0, bin);
    assign h_nxt  = f_hours(r_regs[REG_HOUR], bin, h24);
    assign w_nxt  = f_bump(r_regs[REG_WDAY], 9'd7, 9'd1, bin);
    assign d_nxt  = f_bump(r_regs[REG_DATE], 9'(days), 9'd1, bin);
    assign mo_nxt = f_bump(r_regs[REG_MONTH], 9'd12, 9'd1, bin);
    assign y_nxt  = f_bump(r_regs[REG_YEAR], 9'd99, 9'd0, bin);

    always_comb begin
        n_regs  = r_regs;
        n_presc = r_presc;
        if (ctl_idx == REG_A) begin
            msk = 8'h80;
        end else if (ctl_idx == REG_C || ctl_idx == REG_D) begin
            msk = 8'hff;
        end else begin
            msk = 8'h00;
        end
        if (i_op.acc) begin
            case (i_op.cmd)
                CMD_WRITE: begin
                    if (is_ctl) begin
                        n_regs[ctl_idx] = (r_regs[ctl_idx] & msk) | (i_op.data & ~msk);
                    end
                end
                CMD_READ: begin
                    if (is_ctl && ctl_idx == REG_D) begin
                        n_regs[REG_D] = r_regs[REG_D] | 8'h80;
                    end
                end
                CMD_TICK: begin
                    if (r_presc != 24'd0) begin
                        n_presc = r_presc - 24'd1;
                    end else begin
                        n_presc = r_tps;
                        if (!r_regs[REG_B][7]) begin
                            n_regs[REG_SEC] = s_nxt[7:0];
                            if (s_nxt[8]) begin
                                n_regs[REG_MIN] = m_nxt[7:0];
                                if (m_nxt[8]) begin
                                    n_regs[REG_HOUR] = h_nxt[7:0];
                                    if (h_nxt[8]) begin
                                        n_regs[REG_WDAY] = w_nxt[7:0];
                                        n_regs[REG_DATE] = d_nxt[7:0];
                                        if (d_nxt[8]) begin
                                            n_regs[REG_MONTH] = mo_nxt[7:0];
                                            if (mo_nxt[8]) begin
                                                n_regs[REG_YEAR] = y_nxt[7:0];
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= CTL_RESET;
            r_presc <= '0;
            r_tps   <= TPS_RESET;
        end else begin
            r_regs  <= n_regs;
            r_presc <= n_presc;
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
        end
    end

endmodule

[design/rtc_clock_calendar_regfile.sv]
// top level: bus command stream in, one result item out per command
// Each input item is one bus command (address latch, write, read or clock tick) and yields exactly
// one result item, registered first in the s1 stage and then in the output stage; one item is taken
// every cycle while the output is drained. The clock and control registers live in flip-flops and
// are updated in the cycle an item is accepted; RAM bytes 14..63 sit in a memory with one read and
// one write port, read when the item is accepted and written back when it leaves the s1 stage,
// with a same-address write forwarded to the next read. RAM bytes read as zero until first written.
module rtc_clock_calendar_regfile
    import rtccal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] nvram_changed, [15:9] zero
);

    logic       acc;
    logic       s1_go;
    logic [5:0] r_addr;
    logic       r_s1_vld;
    logic [1:0] r_s1_cmd;
    logic       r_s1_ram;
    logic [5:0] r_s1_addr;
    logic [7:0] r_s1_wdata;
    logic [7:0] r_s1_ctl;
    logic       r_out_vld;
    logic [7:0] r_out_rd;
    logic       r_out_chg;
    logic [7:0] ram_rdata;
    logic [7:0] ctl_rdata;
    logic [7:0] s1_rd;
    logic       s1_chg;
    t_bus_op    op;
    t_ram_req   ram_req;

    assign s1_go    = r_s1_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_s1_vld || s1_go;
    assign acc      = s_tvalid && s_tready;

    assign op.acc  = acc;
    assign op.cmd  = s_tuser;
    assign op.addr = r_addr;
    assign op.data = s_tdata;

    assign ram_req.rd_en   = acc;
    assign ram_req.rd_addr = r_addr;
    assign ram_req.wr_en   = s1_go && r_s1_ram && (r_s1_cmd == CMD_WRITE);
    assign ram_req.wr_addr = r_s1_addr;
    assign ram_req.wr_data = r_s1_wdata;

    rtccal_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (op),
        .o_ctl_rdata (ctl_rdata)
    );

    rtccal_nvram u_nvram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        s1_rd  = 8'h00;
        s1_chg = 1'b0;
        case (r_s1_cmd)
            CMD_READ: begin
                s1_rd = r_s1_ram ? ram_rdata : r_s1_ctl;
            end
            CMD_WRITE: begin
                s1_chg = r_s1_ram && (ram_rdata != r_s1_wdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cmd   <= s_tuser;
            r_s1_ram   <= r_addr >= RAM_BASE;
            r_s1_addr  <= r_addr;
            r_s1_wdata <= s_tdata;
            r_s1_ctl   <= ctl_rdata;
        end
        if (s1_go) begin
            r_out_rd  <= s1_rd;
            r_out_chg <= s1_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc && s_tuser == CMD_ADDR) begin
                r_addr <= s_tdata[5:0];
            end
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {7'd0, r_out_chg, r_out_rd};

endmodule
